/* src/ced_pkg.sv */
`timescale 1ns / 1ps

package ced_pkg;

  // Decoder modes.
  localparam logic [2:0] MODE_NORMAL    = 3'd0;
  localparam logic [2:0] MODE_ESC       = 3'd1;
  localparam logic [2:0] MODE_HEX_FIRST = 3'd2;
  localparam logic [2:0] MODE_HEX_MORE  = 3'd3;
  localparam logic [2:0] MODE_OCT       = 3'd4;
  localparam logic [2:0] MODE_DROP      = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_HEX  = 3'd1;
  localparam logic [2:0] ST_HEX_BIG = 3'd2;
  localparam logic [2:0] ST_UNTERM  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CHAR_BSLASH  = 8'h5c;
  localparam logic [7:0] CHAR_X_LOWER = 8'h78;
  localparam logic [7:0] CHAR_X_UPPER = 8'h58;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_SEVEN   = 8'h37;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_A_LOWER = 8'h61;
  localparam logic [7:0] CHAR_F_LOWER = 8'h66;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [7:0] HEX_LETTER_BASE = 8'h57;  // 'a' - 10

  // Depth of the result queue; one item makes at most two results.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] status;
    logic       string_end;
  } res_t;

  // Results that one character produces.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } dec_t;

  // Returns {valid, value} for a hex digit character.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] l;
    logic [7:0] v;
    l = c | CASE_BIT;
    v = l - HEX_LETTER_BASE;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return {1'b1, c[3:0]};
    end else if (l >= CHAR_A_LOWER && l <= CHAR_F_LOWER) begin
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  // Returns {valid, byte} for a single-letter escape.
  function automatic logic [8:0] single_escape(input logic [7:0] c);
    case (c)
      8'h61:   return {1'b1, 8'h07};  // a, bell
      8'h62:   return {1'b1, 8'h08};  // b, backspace
      8'h66:   return {1'b1, 8'h0c};  // f, form feed
      8'h6e:   return {1'b1, 8'h0a};  // n, newline
      8'h72:   return {1'b1, 8'h0d};  // r, carriage return
      8'h74:   return {1'b1, 8'h09};  // t, tab
      8'h76:   return {1'b1, 8'h0b};  // v, vertical tab
      8'h5c:   return {1'b1, 8'h5c};  // backslash
      8'h27:   return {1'b1, 8'h27};  // single quote
      8'h22:   return {1'b1, 8'h22};  // double quote
      8'h3f:   return {1'b1, 8'h3f};  // question mark
      default: return 9'd0;
    endcase
  endfunction

endpackage

/* src/ced_decode.sv */
`timescale 1ns / 1ps

module ced_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    char_in,
  input  logic          last_char,
  output ced_pkg::dec_t dec
);

  logic [2:0] mode;
  logic [2:0] mode_next;
  logic [7:0] value;
  logic [7:0] value_next;
  logic       overflow;
  logic       overflow_next;
  logic [1:0] oct_count;
  logic [1:0] oct_count_next;

  logic [4:0] hex;
  logic [8:0] sgl;
  logic       is_oct;
  logic       is_x;
  logic       ovf_new;
  logic [7:0] hex_val_new;
  logic [7:0] oct_val_new;
  logic [1:0] oct_count_new;

  // Plain character handling, used alone or after an ended escape.
  logic           plain_has;
  ced_pkg::res_t  plain_res;
  logic [2:0]     plain_mode;

  always_comb begin
    hex           = ced_pkg::hex_nibble(char_in);
    sgl           = ced_pkg::single_escape(char_in);
    is_oct        = (char_in >= ced_pkg::CHAR_ZERO) && (char_in <= ced_pkg::CHAR_SEVEN);
    is_x          = (char_in == ced_pkg::CHAR_X_LOWER) || (char_in == ced_pkg::CHAR_X_UPPER);
    ovf_new       = overflow | (value[7:4] != 4'd0);
    hex_val_new   = {value[3:0], hex[3:0]};
    oct_val_new   = {value[4:0], char_in[2:0]};
    oct_count_new = oct_count + 2'd1;
  end

  always_comb begin
    plain_has  = 1'b1;
    plain_res  = '{data: char_in, status: ced_pkg::ST_OK, string_end: last_char};
    plain_mode = ced_pkg::MODE_NORMAL;
    if (char_in == ced_pkg::CHAR_BSLASH) begin
      if (last_char) begin
        plain_res = '{data: 8'd0, status: ced_pkg::ST_UNTERM, string_end: 1'b1};
      end else begin
        plain_has  = 1'b0;
        plain_mode = ced_pkg::MODE_ESC;
      end
    end
  end

  // Next state and results for the character in hand.
  always_comb begin
    mode_next      = mode;
    value_next     = value;
    overflow_next  = overflow;
    oct_count_next = oct_count;
    dec            = '0;
    case (mode)
      ced_pkg::MODE_ESC: begin
        if (sgl[8]) begin
          dec.count = 2'd1;
          dec.first = '{data: sgl[7:0], status: ced_pkg::ST_OK, string_end: last_char};
          mode_next = ced_pkg::MODE_NORMAL;
        end else if (is_x) begin
          if (last_char) begin
            dec.count = 2'd1;
            dec.first = '{data: 8'd0, status: ced_pkg::ST_NO_HEX, string_end: 1'b1};
            mode_next = ced_pkg::MODE_NORMAL;
          end else begin
            mode_next = ced_pkg::MODE_HEX_FIRST;
          end
        end else if (is_oct) begin
          if (last_char) begin
            dec.count = 2'd1;
            dec.first = '{data: {5'd0, char_in[2:0]}, status: ced_pkg::ST_OK,
                          string_end: 1'b1};
            mode_next = ced_pkg::MODE_NORMAL;
          end else begin
            value_next     = {5'd0, char_in[2:0]};
            oct_count_next = 2'd1;
            mode_next      = ced_pkg::MODE_OCT;
          end
        end else begin
          dec.count = 2'd1;
          dec.first = '{data: 8'd0, status: ced_pkg::ST_UNKNOWN, string_end: 1'b1};
          mode_next = last_char ? ced_pkg::MODE_NORMAL : ced_pkg::MODE_DROP;
        end
      end
      ced_pkg::MODE_HEX_FIRST: begin
        if (!hex[4]) begin
          dec.count = 2'd1;
          dec.first = '{data: 8'd0, status: ced_pkg::ST_NO_HEX, string_end: 1'b1};
          mode_next = last_char ? ced_pkg::MODE_NORMAL : ced_pkg::MODE_DROP;
        end else if (last_char) begin
          dec.count = 2'd1;
          dec.first = '{data: {4'd0, hex[3:0]}, status: ced_pkg::ST_OK, string_end: 1'b1};
          mode_next = ced_pkg::MODE_NORMAL;
        end else begin
          value_next    = {4'd0, hex[3:0]};
          overflow_next = 1'b0;
          mode_next     = ced_pkg::MODE_HEX_MORE;
        end
      end
      ced_pkg::MODE_HEX_MORE: begin
        if (hex[4]) begin
          if (last_char) begin
            dec.count = 2'd1;
            if (ovf_new) begin
              dec.first = '{data: 8'd0, status: ced_pkg::ST_HEX_BIG, string_end: 1'b1};
            end else begin
              dec.first = '{data: hex_val_new, status: ced_pkg::ST_OK, string_end: 1'b1};
            end
            mode_next = ced_pkg::MODE_NORMAL;
          end else begin
            value_next    = hex_val_new;
            overflow_next = ovf_new;
          end
        end else if (overflow) begin
          // The failed escape ends the string and this character is dropped.
          dec.count = 2'd1;
          dec.first = '{data: 8'd0, status: ced_pkg::ST_HEX_BIG, string_end: 1'b1};
          mode_next = last_char ? ced_pkg::MODE_NORMAL : ced_pkg::MODE_DROP;
        end else begin
          dec.count  = plain_has ? 2'd2 : 2'd1;
          dec.first  = '{data: value, status: ced_pkg::ST_OK, string_end: 1'b0};
          dec.second = plain_res;
          mode_next  = plain_mode;
        end
      end
      ced_pkg::MODE_OCT: begin
        if (is_oct) begin
          if (oct_count_new == 2'd3 || last_char) begin
            dec.count = 2'd1;
            dec.first = '{data: oct_val_new, status: ced_pkg::ST_OK, string_end: last_char};
            mode_next = ced_pkg::MODE_NORMAL;
          end else begin
            value_next     = oct_val_new;
            oct_count_next = oct_count_new;
          end
        end else begin
          dec.count  = plain_has ? 2'd2 : 2'd1;
          dec.first  = '{data: value, status: ced_pkg::ST_OK, string_end: 1'b0};
          dec.second = plain_res;
          mode_next  = plain_mode;
        end
      end
      ced_pkg::MODE_DROP: begin
        if (last_char) begin
          mode_next = ced_pkg::MODE_NORMAL;
        end
      end
      default: begin
        dec.count = plain_has ? 2'd1 : 2'd0;
        dec.first = plain_res;
        mode_next = plain_mode;
      end
    endcase
  end

  // Mode register is control state; the escape registers are payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ced_pkg::MODE_NORMAL;
    end else if (step) begin
      mode <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      value     <= value_next;
      overflow  <= overflow_next;
      oct_count <= oct_count_next;
    end
  end

endmodule

/* src/ced_result_queue.sv */
`timescale 1ns / 1ps

module ced_result_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ced_pkg::dec_t dec,
  output logic [1:0]    free,
  output logic          head_valid,
  output ced_pkg::res_t head,
  input  logic          pop
);

  logic [1:0]    count;
  logic [1:0]    count_next;
  logic [1:0]    base;
  logic [1:0]    add;
  ced_pkg::res_t slot0;
  ced_pkg::res_t slot1;

  always_comb begin
    add        = push ? dec.count : 2'd0;
    base       = count - {1'b0, pop};
    count_next = base + add;
    free       = 2'(ced_pkg::QUEUE_DEPTH) - count;
    head_valid = (count != 2'd0);
    head       = slot0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Slot 0 is the head; new beats land behind what remains after a pop.
  always_ff @(posedge clk) begin
    if (add != 2'd0 && base == 2'd0) begin
      slot0 <= dec.first;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (add == 2'd2) begin
      slot1 <= dec.second;
    end else if (add != 2'd0 && base != 2'd0) begin
      slot1 <= dec.first;
    end
  end

endmodule

/* src/c_escape_string_decoder.sv */
`timescale 1ns / 1ps

// Decodes a C-style escaped string, one raw character per input beat, into
// decoded bytes with a status code and an end-of-string mark. A character is
// registered, decoded against the escape state in one pass, and its zero,
// one or two result beats enter a two-entry result queue. The block takes
// one character per cycle while the queue has room. A character that ends
// a hex or octal escape and also stands as a character of its own gives
// two result beats; it waits for room in the queue, and the next character
// with a result may wait too, because room freed by a pop counts only from
// the next cycle. Output stalls add to these waits. Results pass the input
// register and a queue slot. Any error ends the string: later characters
// up to the one marked last give nothing.
module c_escape_string_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] byte_out,
  output logic [2:0] status,
  output logic       string_end
);

  logic          held;
  logic [7:0]    held_char;
  logic          held_last;
  logic          step;
  logic          pop;
  logic [1:0]    free;
  ced_pkg::dec_t dec;
  ced_pkg::res_t head;

  // The held character is decoded once the queue has room for its results.
  assign step     = held && (dec.count <= free);
  assign in_stall = held && !step;
  assign pop      = out_valid && !out_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_char <= char_in;
      held_last <= last_char;
    end
  end

  ced_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_in   (held_char),
    .last_char (held_last),
    .dec       (dec)
  );

  ced_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .dec        (dec),
    .free       (free),
    .head_valid (out_valid),
    .head       (head),
    .pop        (pop)
  );

  assign byte_out   = head.data;
  assign status     = head.status;
  assign string_end = head.string_end;

endmodule

/* src/ced_checker.sv */
`timescale 1ns / 1ps

module ced_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] byte_out,
  input logic [2:0] status,
  input logic       string_end
);

  // An error beat always closes its string and carries a zero byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ced_pkg::ST_OK |-> string_end && byte_out == 8'd0)
    else $error("error beat without string end or with nonzero byte");

  // Status codes stay within the defined set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ced_pkg::ST_OK || status == ced_pkg::ST_NO_HEX ||
                  status == ced_pkg::ST_HEX_BIG || status == ced_pkg::ST_UNTERM ||
                  status == ced_pkg::ST_UNKNOWN)
    else $error("status code out of range");

  // Nothing is offered or held back in the cycle after reset.
  assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid && !in_stall)
    else $error("output valid or input stall right after reset");

  // A stalled result beat stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_out) && $stable(status) &&
                               $stable(string_end))
    else $error("stalled result beat changed");

endmodule

bind c_escape_string_decoder ced_checker u_ced_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .byte_out   (byte_out),
  .status     (status),
  .string_end (string_end)
);

/* verif/ced_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the escape decoder. Every accepted input beat is
// decoded by a local model of the escape state, and every accepted output beat
// is compared with the oldest expected result.
module ced_scoreboard (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       last_char,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] byte_out,
  input  logic [2:0] status,
  input  logic       string_end,
  output int         err_count,
  output int         pending,
  output int         beats_seen,
  output int         error_beats
);

  // Decoded results that are still waiting for their output beat.
  ced_pkg::res_t expected_bytes[$];
  ced_pkg::res_t oldest;

  // Local copy of the escape state.
  logic [2:0] dec_mode;
  logic [7:0] esc_acc;
  logic       hex_big;
  logic [1:0] oct_digits;

  // Returns {is_digit, value} for a hex digit of either case.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | ced_pkg::CASE_BIT;
    if (c >= ced_pkg::CHAR_ZERO && c <= ced_pkg::CHAR_NINE) return {1'b1, c[3:0]};
    // Letters a..f have low nibbles 1..6, so adding 9 gives 10..15.
    if (folded >= ced_pkg::CHAR_A_LOWER && folded <= ced_pkg::CHAR_F_LOWER)
      return {1'b1, folded[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return c >= ced_pkg::CHAR_ZERO && c <= ced_pkg::CHAR_SEVEN;
  endfunction

  task automatic push_result(input logic [7:0] b, input logic [2:0] st, input logic e);
    ced_pkg::res_t r;
    r.data       = b;
    r.status     = st;
    r.string_end = e;
    expected_bytes.push_back(r);
  endtask

  task automatic clear_esc();
    esc_acc    = '0;
    hex_big    = 1'b0;
    oct_digits = '0;
  endtask

  // An error closes the string; the rest of it is dropped unless this was its end.
  task automatic fail_string(input logic [2:0] st, input logic last);
    clear_esc();
    dec_mode = last ? ced_pkg::MODE_NORMAL : ced_pkg::MODE_DROP;
    push_result(8'h00, st, 1'b1);
  endtask

  task automatic plain_char(input logic [7:0] c, input logic last);
    dec_mode = ced_pkg::MODE_NORMAL;
    if (c == ced_pkg::CHAR_BSLASH) begin
      if (last) fail_string(ced_pkg::ST_UNTERM, 1'b1);
      else dec_mode = ced_pkg::MODE_ESC;
    end else begin
      push_result(c, ced_pkg::ST_OK, last);
    end
  endtask

  // Closes a hex escape; an overflowed value becomes an error.
  task automatic end_hex(input logic last, output logic bad);
    logic [7:0] v;
    v = esc_acc;
    bad = hex_big;
    if (hex_big) begin
      fail_string(ced_pkg::ST_HEX_BIG, last);
    end else begin
      clear_esc();
      dec_mode = ced_pkg::MODE_NORMAL;
      push_result(v, ced_pkg::ST_OK, last);
    end
  endtask

  // Advances the model by one character and queues the results it gives.
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [4:0] hv;
    logic [7:0] letter;
    logic       hit;
    logic       bad;
    logic [7:0] v;
    hv = hex_value(c);
    case (dec_mode)
      ced_pkg::MODE_ESC: begin
        hit = 1'b1;
        case (c)
          "a":     letter = 8'h07;
          "b":     letter = 8'h08;
          "f":     letter = 8'h0c;
          "n":     letter = 8'h0a;
          "r":     letter = 8'h0d;
          "t":     letter = 8'h09;
          "v":     letter = 8'h0b;
          "\\":    letter = c;
          "\"":    letter = c;
          "?":     letter = c;
          8'h27:   letter = c;  // single quote
          default: begin
            letter = 8'h00;
            hit = 1'b0;
          end
        endcase
        if (hit) begin
          dec_mode = ced_pkg::MODE_NORMAL;
          push_result(letter, ced_pkg::ST_OK, last);
        end else if (c == ced_pkg::CHAR_X_LOWER || c == ced_pkg::CHAR_X_UPPER) begin
          clear_esc();
          dec_mode = ced_pkg::MODE_HEX_FIRST;
          if (last) fail_string(ced_pkg::ST_NO_HEX, 1'b1);
        end else if (is_octal(c)) begin
          esc_acc = c - ced_pkg::CHAR_ZERO;
          oct_digits = 2'd1;
          if (last) begin
            v = esc_acc;
            clear_esc();
            dec_mode = ced_pkg::MODE_NORMAL;
            push_result(v, ced_pkg::ST_OK, 1'b1);
          end else begin
            dec_mode = ced_pkg::MODE_OCT;
          end
        end else begin
          fail_string(ced_pkg::ST_UNKNOWN, last);
        end
      end
      ced_pkg::MODE_HEX_FIRST: begin
        if (!hv[4]) begin
          fail_string(ced_pkg::ST_NO_HEX, last);
        end else begin
          esc_acc = {4'd0, hv[3:0]};
          hex_big = 1'b0;
          dec_mode = ced_pkg::MODE_HEX_MORE;
          if (last) end_hex(1'b1, bad);
        end
      end
      ced_pkg::MODE_HEX_MORE: begin
        if (hv[4]) begin
          if (esc_acc[7:4] != 4'd0) hex_big = 1'b1;
          esc_acc = {esc_acc[3:0], hv[3:0]};
          if (last) end_hex(1'b1, bad);
        end else begin
          // The terminating character is decoded on its own unless the hex failed.
          end_hex(1'b0, bad);
          if (bad) dec_mode = last ? ced_pkg::MODE_NORMAL : ced_pkg::MODE_DROP;
          else plain_char(c, last);
        end
      end
      ced_pkg::MODE_OCT: begin
        if (is_octal(c)) begin
          esc_acc = (esc_acc << 3) | (c - ced_pkg::CHAR_ZERO);
          oct_digits = oct_digits + 2'd1;
          if (oct_digits == 2'd3 || last) begin
            v = esc_acc;
            clear_esc();
            dec_mode = ced_pkg::MODE_NORMAL;
            push_result(v, ced_pkg::ST_OK, last);
          end
        end else begin
          v = esc_acc;
          clear_esc();
          push_result(v, ced_pkg::ST_OK, 1'b0);
          plain_char(c, last);
        end
      end
      ced_pkg::MODE_DROP: begin
        if (last) dec_mode = ced_pkg::MODE_NORMAL;
      end
      default: begin
        plain_char(c, last);
      end
    endcase
  endtask

  task automatic note_mismatch(input string field, input int exp_v, input int act_v);
    err_count++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
  endtask

  // Check the output beat first, then model the input beat of the same edge.
  always @(posedge clk) begin
    if (rst) begin
      dec_mode = ced_pkg::MODE_NORMAL;
      clear_esc();
      expected_bytes.delete();
      err_count   = 0;
      beats_seen  = 0;
      error_beats = 0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (status != ced_pkg::ST_OK) error_beats++;
        if (expected_bytes.size() == 0) begin
          err_count++;
          $display("%0t: unexpected beat, expected none, actual byte 0x%0h status %0d end %0d",
                   $time, byte_out, status, string_end);
        end else begin
          oldest = expected_bytes.pop_front();
          if (byte_out !== oldest.data) note_mismatch("byte_out", oldest.data, byte_out);
          if (status !== oldest.status) note_mismatch("status", oldest.status, status);
          if (string_end !== oldest.string_end)
            note_mismatch("string_end", oldest.string_end, string_end);
        end
      end
      if (in_valid && !in_stall) decode_char(char_in, last_char);
    end
    pending = expected_bytes.size();
  end

endmodule

/* verif/tb_c_escape_string_decoder.sv */
`timescale 1ns / 1ps

module tb_c_escape_string_decoder;

  localparam logic [7:0] CHAR_QUOTE    = 8'h27;
  localparam string      ESC_LETTERS   = "abfnrtv\\\"?";
  localparam int         PHASE_CHARS   = 125;
  localparam int         HOLD_CYCLES   = 60;
  localparam int         DRAIN_CYCLES  = 10;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] char_in   = 8'h00;
  logic       last_char = 1'b0;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire  [7:0] byte_out;
  wire  [2:0] status;
  wire        string_end;

  int err_count;
  int pending;
  int beats_seen;
  int error_beats;

  // Traffic shaping: the sender's idle share is local to the stimulus process,
  // the receiver's stall share and hold request are handed over by NBA.
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_req      = 1'b0;
  logic hold_seen     = 1'b0;
  int   hold_left     = 0;
  int   chars_sent    = 0;
  int   phase_chars;

  logic [7:0] text_q[$];

  c_escape_string_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_in    (char_in),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .byte_out   (byte_out),
    .status     (status),
    .string_end (string_end)
  );

  ced_scoreboard u_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_in     (char_in),
    .last_char   (last_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .byte_out    (byte_out),
    .status      (status),
    .string_end  (string_end),
    .err_count   (err_count),
    .pending     (pending),
    .beats_seen  (beats_seen),
    .error_beats (error_beats)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold counted here once requested.
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one character and returns at the edge where it was taken.
  task automatic send_beat(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_in   <= c;
    last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  // Sends the queued string, marking its final character.
  task automatic send_text();
    foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) text_q.push_back(s[i]);
  endtask

  task automatic add_hex_digit();
    logic [3:0] v;
    v = 4'($urandom_range(15));
    if (v < 4'd10) text_q.push_back(ced_pkg::CHAR_ZERO + v);
    else if ($urandom_range(1)) text_q.push_back(ced_pkg::CHAR_A_LOWER + v - 8'd10);
    else text_q.push_back((ced_pkg::CHAR_A_LOWER & ~ced_pkg::CASE_BIT) + v - 8'd10);
  endtask

  // Builds one string: plain characters and mostly well-formed escapes with random content, some noise.
  task automatic build_random_text();
    int n_tok;
    int kind;
    int pick;
    int n_dig;
    n_tok = $urandom_range(1, 6);
    repeat (n_tok) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        // Plain character, now and then any byte at all.
        if ($urandom_range(9) == 0) text_q.push_back(8'($urandom_range(255)));
        else text_q.push_back(8'($urandom_range(8'h7e, 8'h20)));
      end else if (kind < 55) begin
        text_q.push_back(ced_pkg::CHAR_BSLASH);
        pick = $urandom_range(ESC_LETTERS.len());
        if (pick == ESC_LETTERS.len()) text_q.push_back(CHAR_QUOTE);
        else text_q.push_back(ESC_LETTERS[pick]);
      end else if (kind < 70) begin
        text_q.push_back(ced_pkg::CHAR_BSLASH);
        text_q.push_back($urandom_range(1) ? ced_pkg::CHAR_X_LOWER : ced_pkg::CHAR_X_UPPER);
        n_dig = $urandom_range(1, 3);
        repeat (n_dig) add_hex_digit();
      end else if (kind < 85) begin
        text_q.push_back(ced_pkg::CHAR_BSLASH);
        n_dig = $urandom_range(1, 3);
        repeat (n_dig) text_q.push_back(ced_pkg::CHAR_ZERO + 8'($urandom_range(7)));
      end else begin
        // Broken escapes: stray backslash, a random byte or bare hex prefix.
        text_q.push_back(ced_pkg::CHAR_BSLASH);
        pick = $urandom_range(2);
        if (pick == 0) text_q.push_back(8'($urandom_range(255)));
        else if (pick == 1) text_q.push_back(ced_pkg::CHAR_X_LOWER);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings: byte extremes, octal wrap, hex digits of both cases,
    // hex overflow, dangling backslash, missing hex digit, an escape closed by
    // a new backslash, and an unknown escape whose string is then dropped.
    text_q.push_back(8'h00);
    text_q.push_back(8'hff);
    add_text("\\777");
    send_text();
    add_text("\\Xab");
    send_text();
    add_text("\\x1F0");
    send_text();
    add_text("\\");
    send_text();
    add_text("\\x");
    send_text();
    add_text("\\xg");
    send_text();
    add_text("\\12\\");
    send_text();
    add_text("\\qz");
    send_text();

    // Random strings under four traffic mixes; the first also gets the long hold.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
          hold_req <= 1'b1;
        end
        1: begin
          send_idle_pct = 58;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 58;
        end
        default: begin
          send_idle_pct = 36;
          stall_pct <= 36;
        end
      endcase
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        build_random_text();
        phase_chars += text_q.size();
        send_text();
      end
    end

    in_valid  <= 1'b0;
    stall_pct <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Decoded %0d characters into %0d result beats, %0d of them error beats.",
             chars_sent, beats_seen, error_beats);
    $display("Traffic ran with no gaps, sender gaps, receiver stalls, both, and one long hold.");
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
